// ----- rtl/core/hss_pkg.sv -----
// Shared types and constants for the household SIS event-step block.
// No dependencies; imported by hss_div and household_sis_gillespie_step.
`timescale 1ns / 1ps

package hss_pkg;

   // per-household count width (susceptible and infected)
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // one seeded household per this many households on init
   localparam int SEED_DIV = 10;

   // request opcodes
   localparam logic OP_INIT = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // event kinds
   localparam logic KIND_INFECT  = 1'b0;
   localparam logic KIND_RECOVER = 1'b1;

   // register map (word index)
   localparam int CFG_AW = 5;
   localparam logic [2:0] REG_ALPHA  = 3'd0;
   localparam logic [2:0] REG_BETA   = 3'd1;
   localparam logic [2:0] REG_GAMMA  = 3'd2;
   localparam logic [2:0] REG_HOUSES = 3'd3;
   localparam logic [2:0] REG_PEOPLE = 3'd4;

   localparam logic [15:0] ALPHA_RST  = 16'd410;
   localparam logic [15:0] BETA_RST   = 16'd410;
   localparam logic [15:0] GAMMA_RST  = 16'd614;
   localparam logic [11:0] HOUSES_RST = 12'd1500;
   localparam logic [3:0]  PEOPLE_RST = 4'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/household_sis_gillespie_step.sv -----
// Household SIS epidemic, one direct-method event per step request.
// Depends on hss_pkg and hss_div.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high
// until the single result is strobed on rsp_valid for one cycle, which the
// receiver must take. Per-household counts live in one memory with one read
// and one write per cycle, so time scales with H, the effective household
// count. An init request sweeps the memory once. An event request makes three
// read passes (totals, rate sum, selection) and up to three runs of the shared
// divider, of width DW = max(clog2(MAX_HOUSES) + 30, 36), 41 by default.
// Counts are undefined until the first init request.
module household_sis_gillespie_step import hss_pkg::*; #(
   parameter int MAX_HOUSES    = 2048,
   parameter int MAX_PER_HOUSE = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [15:0]       req_exp_sample,
   input  logic [15:0]       req_uniform_sample,
   // result
   output logic              rsp_valid,
   output logic [10:0]       rsp_event_household,
   output logic              rsp_event_kind,
   output logic [31:0]       rsp_wait_time,
   output logic [14:0]       rsp_infected_total,
   output logic [14:0]       rsp_susceptible_total,
   output logic              rsp_died_out,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CFG_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int HW  = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1;
   localparam int HCW = HW + 1;
   localparam int CW  = (HCW > 12) ? HCW : 12;
   localparam int MW  = HCW + 4;
   localparam int SW  = HW + CNT_W;
   localparam int XW  = (SW > 15) ? SW : 15;
   localparam int EW  = 24;                 // eps and within term
   localparam int AW  = 29;                 // infection rate of one house
   localparam int GW  = 24;                 // recovery rate of one house
   localparam int TW  = 30;                 // total rate of one house
   localparam int RW  = HW + TW;            // rate sum
   localparam int DW  = (RW > 36) ? RW : 36;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SUM, ST_EPS_MUL, ST_EPS_DIV, ST_WB_DIV, ST_WTAB,
      ST_RATE, ST_P_MUL, ST_P_ADD, ST_SELECT, ST_UPDATE, ST_WAIT_DIV
   } state_type;

   function automatic logic [14:0] sat15(input logic [SW-1:0] v);
      logic [XW-1:0] x;
      x = XW'(v);
      return (x > XW'(32767)) ? 15'h7FFF : x[14:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [15:0] alpha_ff, beta_ff, gamma_ff;
   logic [11:0] houses_ff;
   logic [3:0]  people_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RST;
         beta_ff   <= BETA_RST;
         gamma_ff  <= GAMMA_RST;
         houses_ff <= HOUSES_RST;
         people_ff <= PEOPLE_RST;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_ALPHA:  alpha_ff  <= pwdata[15:0];
            REG_BETA:   beta_ff   <= pwdata[15:0];
            REG_GAMMA:  gamma_ff  <= pwdata[15:0];
            REG_HOUSES: houses_ff <= pwdata[11:0];
            REG_PEOPLE: people_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_ALPHA:  prdata = {16'd0, alpha_ff};
         REG_BETA:   prdata = {16'd0, beta_ff};
         REG_GAMMA:  prdata = {16'd0, gamma_ff};
         REG_HOUSES: prdata = {20'd0, houses_ff};
         REG_PEOPLE: prdata = {28'd0, people_ff};
         default:    prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // effective household count and household size
   logic [CW-1:0]    hc_w;
   logic [HCW-1:0]   hn;
   logic [CNT_W-1:0] np;

   assign hc_w = CW'(houses_ff);
   always_comb begin
      if (hc_w == '0)                    hn = HCW'(1);
      else if (hc_w > CW'(MAX_HOUSES))   hn = HCW'(MAX_HOUSES);
      else                               hn = HCW'(hc_w);
      if (people_ff == '0)                       np = CNT_W'(1);
      else if (people_ff > 4'(MAX_PER_HOUSE))    np = CNT_W'(MAX_PER_HOUSE);
      else                                       np = people_ff;
   end

   // ---------------- sequencer registers ----------------
   state_type        state_ff;
   logic             rsp_valid_ff;
   logic [10:0]      rsp_house_ff;
   logic             rsp_kind_ff;
   logic [31:0]      rsp_wait_ff;
   logic [14:0]      isum_ff, ssum_ff;

   logic [15:0]      exp_ff, u_ff;
   logic [HCW-1:0]   iss_cnt_ff;
   logic [MW-1:0]    seed_mark_ff;
   logic [SW-1:0]    tot_i_ff, tot_s_ff;
   logic [EW-1:0]    eps_ff;
   logic [19:0]      qb_ff;
   logic [CNT_W-1:0] rb_ff, d_ff, tbl_idx_ff;
   logic [EW-1:0]    tq_ff;
   logic [CNT_W:0]   tr_ff;
   logic [EW-1:0]    w_tbl [2**CNT_W];
   logic [RW-1:0]    rtot_ff, p_hi_ff, p_ff, cum_ff;
   logic [15:0]      p_lo_ff;
   logic             found_ff;
   logic [HW-1:0]    ev_house_ff;
   logic             ev_kind_ff;
   logic [CNT_W-1:0] ev_s_ff, ev_i_ff;
   logic             div_start_ff;
   logic [DW-1:0]    div_num_ff, div_den_ff;

   // divider
   div_status_type div_stat;
   logic [DW-1:0]  div_quo, div_rem;

   hss_div #(.W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // ---------------- count memory and read stream ----------------
   logic [2*CNT_W-1:0] mem [MAX_HOUSES];
   logic [2*CNT_W-1:0] rd_word_ff;
   logic               rd_vld_ff;
   logic [HW-1:0]      rd_idx_ff;
   logic               iss_en, iss_more;
   logic [HW-1:0]      iss_addr;
   logic               mem_we;
   logic [HW-1:0]      mem_waddr;
   logic [2*CNT_W-1:0] mem_wdata;
   logic               seed_now;
   logic [CNT_W-1:0]   upd_s, upd_i;

   assign iss_more = iss_cnt_ff < hn;
   assign iss_addr = iss_cnt_ff[HW-1:0];
   assign iss_en   = iss_more &&
                     (state_ff == ST_SUM || state_ff == ST_RATE || state_ff == ST_SELECT);
   assign seed_now = seed_mark_ff <= MW'(hn);

   // event applied to the chosen household, counts clamp at 0 and full scale
   always_comb begin
      upd_s = ev_s_ff;
      upd_i = ev_i_ff;
      if (ev_kind_ff == KIND_INFECT) begin
         if (ev_s_ff != '0)      upd_s = ev_s_ff - 1'b1;
         if (ev_i_ff != CNT_MAX) upd_i = ev_i_ff + 1'b1;
      end else begin
         if (ev_i_ff != '0)      upd_i = ev_i_ff - 1'b1;
         if (ev_s_ff != CNT_MAX) upd_s = ev_s_ff + 1'b1;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = iss_addr;
      mem_wdata = {np, {CNT_W{1'b0}}};
      if (state_ff == ST_INIT && iss_more) begin
         mem_we = 1'b1;
         if (seed_now) mem_wdata = {np - 1'b1, CNT_W'(1)};
      end else if (state_ff == ST_UPDATE) begin
         mem_we    = 1'b1;
         mem_waddr = ev_house_ff;
         mem_wdata = {upd_s, upd_i};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (iss_en) rd_word_ff <= mem[iss_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= iss_en;
      rd_idx_ff <= iss_addr;
   end

   // ---------------- rate stage ----------------
   logic [CNT_W-1:0] rd_s, rd_i;
   logic [EW:0]      infect_base;
   logic             rt_vld_ff;
   logic [AW-1:0]    a_ff;
   logic [GW-1:0]    r_ff;
   logic [HW-1:0]    rt_idx_ff;
   logic [CNT_W-1:0] rt_s_ff, rt_i_ff;

   assign rd_s        = rd_word_ff[2*CNT_W-1:CNT_W];
   assign rd_i        = rd_word_ff[CNT_W-1:0];
   assign infect_base = {1'b0, eps_ff} + {1'b0, w_tbl[rd_i]};

   always_ff @(posedge clock) begin
      if (reset) rt_vld_ff <= 1'b0;
      else       rt_vld_ff <= rd_vld_ff;
      a_ff      <= AW'(infect_base) * AW'(rd_s);
      r_ff      <= GW'({gamma_ff, 4'd0}) * GW'(rd_i);
      rt_idx_ff <= rd_idx_ff;
      rt_s_ff   <= rd_s;
      rt_i_ff   <= rd_i;
   end

   // ---------------- sequencer datapath helpers ----------------
   logic          pass_done;
   logic [TW-1:0] t_sum;
   logic [RW-1:0] cum_next, p_rem;
   logic [EW-1:0] tq_next;
   logic [CNT_W:0] tr_sum, tr_next;
   logic [31:0]   wait_sat;

   assign pass_done = !iss_more && !rd_vld_ff && !rt_vld_ff;
   assign t_sum     = TW'(a_ff) + TW'(r_ff);
   assign cum_next  = cum_ff + RW'(t_sum);
   assign p_rem     = p_ff - cum_ff;
   assign tr_sum    = tr_ff + (CNT_W+1)'(rb_ff);
   assign wait_sat  = (div_quo > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];

   // running quotient and remainder build w[I] = floor(B*I/d) one step at a time
   always_comb begin
      tq_next = tq_ff + EW'(qb_ff);
      tr_next = tr_sum;
      if (tr_sum >= (CNT_W+1)'(d_ff)) begin
         tr_next = tr_sum - (CNT_W+1)'(d_ff);
         tq_next = tq_ff + EW'(qb_ff) + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         isum_ff      <= '0;
         ssum_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  exp_ff       <= req_exp_sample;
                  u_ff         <= req_uniform_sample;
                  iss_cnt_ff   <= '0;
                  tot_i_ff     <= '0;
                  tot_s_ff     <= '0;
                  seed_mark_ff <= MW'(SEED_DIV);
                  state_ff     <= (req_op == OP_INIT) ? ST_INIT : ST_SUM;
               end
            end
            ST_INIT: begin
               if (iss_more) begin
                  iss_cnt_ff   <= iss_cnt_ff + 1'b1;
                  seed_mark_ff <= seed_mark_ff + MW'(SEED_DIV);
                  if (seed_now) begin
                     tot_i_ff <= tot_i_ff + SW'(1);
                     tot_s_ff <= tot_s_ff + SW'(np - 1'b1);
                  end else begin
                     tot_s_ff <= tot_s_ff + SW'(np);
                  end
               end else begin
                  rsp_house_ff <= '0;
                  rsp_kind_ff  <= KIND_INFECT;
                  rsp_wait_ff  <= '0;
                  isum_ff      <= sat15(tot_i_ff);
                  ssum_ff      <= sat15(tot_s_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SUM: begin
               if (iss_en) iss_cnt_ff <= iss_cnt_ff + 1'b1;
               if (rd_vld_ff) begin
                  tot_i_ff <= tot_i_ff + SW'(rd_i);
                  tot_s_ff <= tot_s_ff + SW'(rd_s);
               end
               if (pass_done) state_ff <= ST_EPS_MUL;
            end
            ST_EPS_MUL: begin
               div_num_ff   <= DW'({alpha_ff, 4'd0}) * DW'(tot_i_ff);
               div_den_ff   <= DW'(hn) * DW'(np);
               div_start_ff <= 1'b1;
               state_ff     <= ST_EPS_DIV;
            end
            ST_EPS_DIV: begin
               if (div_stat.done) begin
                  eps_ff     <= div_quo[EW-1:0];
                  tq_ff      <= '0;
                  tr_ff      <= '0;
                  tbl_idx_ff <= CNT_W'(1);
                  w_tbl[0]   <= '0;
                  if (np > CNT_W'(1)) begin
                     div_num_ff   <= DW'({beta_ff, 4'd0});
                     div_den_ff   <= DW'(np - 1'b1);
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_WB_DIV;
                  end else begin
                     qb_ff    <= {beta_ff, 4'd0};
                     rb_ff    <= '0;
                     d_ff     <= CNT_W'(1);
                     state_ff <= ST_WTAB;
                  end
               end
            end
            ST_WB_DIV: begin
               if (div_stat.done) begin
                  qb_ff    <= div_quo[19:0];
                  rb_ff    <= div_rem[CNT_W-1:0];
                  d_ff     <= np - 1'b1;
                  state_ff <= ST_WTAB;
               end
            end
            ST_WTAB: begin
               w_tbl[tbl_idx_ff]   <= tq_next;
               tq_ff               <= tq_next;
               tr_ff               <= tr_next;
               tbl_idx_ff          <= tbl_idx_ff + 1'b1;
               if (tbl_idx_ff == CNT_MAX) begin
                  iss_cnt_ff <= '0;
                  rtot_ff    <= '0;
                  state_ff   <= ST_RATE;
               end
            end
            ST_RATE: begin
               if (iss_en) iss_cnt_ff <= iss_cnt_ff + 1'b1;
               if (rt_vld_ff) rtot_ff <= rtot_ff + RW'(t_sum);
               if (pass_done) begin
                  if (rtot_ff == '0) begin
                     // nothing can happen: counts stay, wait is infinite
                     rsp_house_ff <= '0;
                     rsp_kind_ff  <= KIND_INFECT;
                     rsp_wait_ff  <= 32'hFFFF_FFFF;
                     isum_ff      <= sat15(tot_i_ff);
                     ssum_ff      <= sat15(tot_s_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_P_MUL;
                  end
               end
            end
            ST_P_MUL: begin
               p_hi_ff  <= RW'(rtot_ff[RW-1:16]) * RW'(u_ff);
               p_lo_ff  <= 16'((32'(rtot_ff[15:0]) * 32'(u_ff)) >> 16);
               state_ff <= ST_P_ADD;
            end
            ST_P_ADD: begin
               p_ff       <= p_hi_ff + RW'(p_lo_ff);
               cum_ff     <= '0;
               found_ff   <= 1'b0;
               iss_cnt_ff <= '0;
               state_ff   <= ST_SELECT;
            end
            ST_SELECT: begin
               if (iss_en) iss_cnt_ff <= iss_cnt_ff + 1'b1;
               // first household with nonzero rate whose running sum reaches p
               if (rt_vld_ff && !found_ff && t_sum != '0) begin
                  cum_ff <= cum_next;
                  if (cum_next >= p_ff) begin
                     found_ff    <= 1'b1;
                     ev_house_ff <= rt_idx_ff;
                     ev_s_ff     <= rt_s_ff;
                     ev_i_ff     <= rt_i_ff;
                     ev_kind_ff  <= (a_ff != '0 && RW'(a_ff) >= p_rem) ?
                                    KIND_INFECT : KIND_RECOVER;
                  end
               end
               if (pass_done) state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               tot_s_ff     <= tot_s_ff - SW'(ev_s_ff) + SW'(upd_s);
               tot_i_ff     <= tot_i_ff - SW'(ev_i_ff) + SW'(upd_i);
               div_num_ff   <= DW'(exp_ff) << 20;
               div_den_ff   <= DW'(rtot_ff);
               div_start_ff <= 1'b1;
               state_ff     <= ST_WAIT_DIV;
            end
            ST_WAIT_DIV: begin
               if (div_stat.done) begin
                  rsp_house_ff <= 11'(ev_house_ff);
                  rsp_kind_ff  <= ev_kind_ff;
                  rsp_wait_ff  <= wait_sat;
                  isum_ff      <= sat15(tot_i_ff);
                  ssum_ff      <= sat15(tot_s_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy                  = state_ff != ST_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_household   = rsp_house_ff;
   assign rsp_event_kind        = rsp_kind_ff;
   assign rsp_wait_time         = rsp_wait_ff;
   assign rsp_infected_total    = isum_ff;
   assign rsp_susceptible_total = ssum_ff;
   assign rsp_died_out          = isum_ff == '0;

   // ---------------- assertions ----------------
   a_done_has_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> !div_stat.busy)
      else $error("divider started while busy");

   a_select_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> found_ff)
      else $error("selection pass ended without a household");

endmodule

// ----- rtl/core/hss_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on hss_pkg (status struct).
`timescale 1ns / 1ps

module hss_div import hss_pkg::*; #(
   parameter int W = 36
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   num,
   input  logic [W-1:0]   den,
   output div_status_type stat,
   output logic [W-1:0]   quo,
   output logic [W-1:0]   rem
);

   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    quo_ff, rem_ff, den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff;
   logic [W:0]      trial, diff;
   logic            ge;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            quo_ff  <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            cnt_ff  <= CNTW'(W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[W-2:0], ge};
            rem_ff <= ge ? diff[W-1:0] : trial[W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;
   assign rem       = rem_ff;

endmodule

// ----- verif/testbench.sv -----
// Testbench for household_sis_gillespie_step: directed and random init/event requests,
// with an event-step predictor and an in-order result scoreboard. Depends on hss_pkg.
`timescale 1ns / 1ps

class epidemic_scoreboard;
   // configuration copy
   int unsigned alpha_q, beta_q, gamma_q, houses_q, people_q;
   // population copy
   int unsigned sus_cnt[2048];
   int unsigned inf_cnt[2048];
   int unsigned inf_sum, sus_sum;
   // expected results, oldest first
   logic [10:0] exp_house[$];
   logic        exp_kind[$];
   logic [31:0] exp_wait[$];
   logic [14:0] exp_inf[$];
   logic [14:0] exp_sus[$];
   int mismatches;
   int checked;

   function new();
      alpha_q = 410; beta_q = 410; gamma_q = 614; houses_q = 1500; people_q = 2;
      inf_sum = 0; sus_sum = 0; mismatches = 0; checked = 0;
      foreach (sus_cnt[i]) begin
         sus_cnt[i] = 0;
         inf_cnt[i] = 0;
      end
   endfunction

   function void set_reg(int idx, int unsigned val);
      case (idx)
         hss_pkg::REG_ALPHA:  alpha_q  = val & 16'hFFFF;
         hss_pkg::REG_BETA:   beta_q   = val & 16'hFFFF;
         hss_pkg::REG_GAMMA:  gamma_q  = val & 16'hFFFF;
         hss_pkg::REG_HOUSES: houses_q = val & 12'hFFF;
         hss_pkg::REG_PEOPLE: people_q = val & 4'hF;
         default: ;
      endcase
   endfunction

   function int unsigned eff_houses();
      if (houses_q == 0) return 1;
      if (houses_q > 2048) return 2048;
      return houses_q;
   endfunction

   function int unsigned eff_people();
      if (people_q == 0) return 1;
      if (people_q > 8) return 8;
      return people_q;
   endfunction

   function longint unsigned infection_rate(int h, longint unsigned eps, int unsigned n);
      longint unsigned w, r;
      w = (longint'(beta_q) << 4) * inf_cnt[h];
      if (n > 1) w = w / (n - 1);
      r = (eps + w) * sus_cnt[h];
      return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
   endfunction

   function void recount(int unsigned hn);
      longint unsigned si, ss;
      si = 0; ss = 0;
      for (int h = 0; h < hn; h++) begin
         si += inf_cnt[h];
         ss += sus_cnt[h];
      end
      inf_sum = (si > 32767) ? 32767 : si;
      sus_sum = (ss > 32767) ? 32767 : ss;
   endfunction

   // note an accepted request and queue the result it must produce
   function void note_request(logic op, logic [15:0] expv, logic [15:0] u);
      int unsigned hn, n, house, kind;
      longint unsigned tot_i, eps, rtotal, p, cum, a, t, rem, q;
      logic [31:0] wait_v;
      hn = eff_houses(); n = eff_people();
      house = 0; kind = hss_pkg::KIND_INFECT; wait_v = 0;
      if (op == hss_pkg::OP_INIT) begin
         for (int h = 0; h < hn; h++) begin
            sus_cnt[h] = (h < hn / hss_pkg::SEED_DIV) ? n - 1 : n;
            inf_cnt[h] = (h < hn / hss_pkg::SEED_DIV) ? 1 : 0;
         end
      end else begin
         tot_i = 0; rtotal = 0;
         for (int h = 0; h < hn; h++) tot_i += inf_cnt[h];
         eps = ((longint'(alpha_q) << 4) * tot_i) / (longint'(hn) * n);
         for (int h = 0; h < hn; h++)
            rtotal += infection_rate(h, eps, n) + (longint'(gamma_q) << 4) * inf_cnt[h];
         if (rtotal == 0) begin
            wait_v = 32'hFFFF_FFFF;
         end else begin
            p = (rtotal >> 16) * u + (((rtotal & 16'hFFFF) * u) >> 16);
            cum = 0;
            kind = hss_pkg::KIND_RECOVER;
            for (int h = 0; h < hn; h++) begin
               a = infection_rate(h, eps, n);
               t = a + (longint'(gamma_q) << 4) * inf_cnt[h];
               if (t != 0) begin
                  cum += t;
                  if (cum >= p) begin
                     rem = p - (cum - t);
                     house = h;
                     kind = (a > 0 && a >= rem) ? hss_pkg::KIND_INFECT : hss_pkg::KIND_RECOVER;
                     break;
                  end
               end
            end
            if (kind == hss_pkg::KIND_INFECT) begin
               if (sus_cnt[house] > 0) sus_cnt[house]--;
               if (inf_cnt[house] < 15) inf_cnt[house]++;
            end else begin
               if (inf_cnt[house] > 0) inf_cnt[house]--;
               if (sus_cnt[house] < 15) sus_cnt[house]++;
            end
            q = (longint'(expv) << 20) / rtotal;
            wait_v = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         end
      end
      recount(hn);
      exp_house.insert(exp_house.size(), house[10:0]);
      exp_kind.insert(exp_kind.size(), kind[0]);
      exp_wait.insert(exp_wait.size(), wait_v);
      exp_inf.insert(exp_inf.size(), inf_sum[14:0]);
      exp_sus.insert(exp_sus.size(), sus_sum[14:0]);
   endfunction

   function void report(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endfunction

   function void check_result(logic [10:0] house, logic kind, logic [31:0] wait_v,
                              logic [14:0] inf, logic [14:0] sus, logic dead);
      logic [10:0] e_house;
      logic        e_kind;
      logic [31:0] e_wait;
      logic [14:0] e_inf, e_sus;
      if (exp_house.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("result with no request outstanding");
         return;
      end
      e_house = exp_house.pop_front(); e_kind = exp_kind.pop_front();
      e_wait = exp_wait.pop_front(); e_inf = exp_inf.pop_front(); e_sus = exp_sus.pop_front();
      checked++;
      if (house !== e_house) report("event_household", e_house, house);
      if (kind !== e_kind) report("event_kind", e_kind, kind);
      if (wait_v !== e_wait) report("wait_time", e_wait, wait_v);
      if (inf !== e_inf) report("infected_total", e_inf, inf);
      if (sus !== e_sus) report("susceptible_total", e_sus, sus);
      if (dead !== (e_inf == 0)) report("died_out", e_inf == 0, dead);
   endfunction

   function int outstanding();
      return exp_house.size();
   endfunction
endclass

module testbench;
   import hss_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_INIT;
   logic [15:0] req_exp_sample = '0;
   logic [15:0] req_uniform_sample = '0;
   logic rsp_valid;
   logic [10:0] rsp_event_household;
   logic rsp_event_kind;
   logic [31:0] rsp_wait_time;
   logic [14:0] rsp_infected_total, rsp_susceptible_total;
   logic rsp_died_out;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CFG_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   epidemic_scoreboard board = new();
   int step_count = 0;
   int init_count = 0;

   household_sis_gillespie_step uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid)
         board.check_result(rsp_event_household, rsp_event_kind, rsp_wait_time,
                            rsp_infected_total, rsp_susceptible_total, rsp_died_out);

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = CFG_AW'(idx) << 2; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, val);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic send_request(logic op, logic [15:0] expv, logic [15:0] u, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
      repeat (gap) @(negedge clock);
      req_op = op; req_exp_sample = expv; req_uniform_sample = u; start = 1'b1;
      do @(posedge clock); while (busy);
      board.note_request(op, expv, u);
      if (op == OP_INIT) init_count++; else step_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // drain all results, then let the block settle
   task automatic wait_idle();
      while (board.outstanding() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic configure(int unsigned a, int unsigned b, int unsigned g,
                            int unsigned hh, int unsigned pp);
      wait_idle();
      write_reg(REG_ALPHA, a);
      write_reg(REG_BETA, b);
      write_reg(REG_GAMMA, g);
      write_reg(REG_HOUSES, hh);
      write_reg(REG_PEOPLE, pp);
   endtask

   task automatic random_steps(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_request(OP_INIT, $urandom, $urandom);
         else
            send_request(OP_STEP, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: small population, field extremes
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 12, 3);
      send_request(OP_INIT, 16'h0000, 16'h0000);
      send_request(OP_STEP, 16'h0000, 16'h0000);
      send_request(OP_STEP, 16'hFFFF, 16'hFFFF);
      send_request(OP_STEP, 16'h1000, 16'h8000);
      send_request(OP_STEP, 16'h5555, 16'hAAAA);
      send_request(OP_STEP, 16'hAAAA, 16'h5555, 1);
      // zero rates: no event possible
      configure(0, 0, 0, 12, 3);
      send_request(OP_STEP, 16'h1234, 16'h4321);
      // fewer than ten houses: nobody seeded, so the epidemic is already over
      configure(410, 410, 614, 5, 1);
      send_request(OP_INIT, 16'hFFFF, 16'hFFFF);
      send_request(OP_STEP, 16'h7FFF, 16'h7FFF);
      // out-of-range house and people counts, single-person houses
      configure(1, 0, 16'hFFFF, 0, 0);
      send_request(OP_INIT, 0, 0);
      send_request(OP_STEP, 16'hFFFF, 0);
      configure(16'h8000, 16'h8000, 1, 20, 15);
      send_request(OP_INIT, 0, 0);
      send_request(OP_STEP, 16'h0001, 16'hFFFF);
      send_request(OP_STEP, 16'hFFFF, 16'h0001);
      // shrink people per house without re-init: counts may exceed n
      configure(16'hFFFF, 16'hFFFF, 1, 20, 1);
      send_request(OP_STEP, 16'h8000, 16'h0000);
      send_request(OP_STEP, 16'h8000, 16'hFFFF);
      // maximum house count, then an out-of-range count that clamps to it
      configure(410, 410, 614, 2048, 8);
      send_request(OP_INIT, 16'h2000, 16'h2000);
      send_request(OP_STEP, 16'h2000, 16'hC000);
      configure(410, 410, 614, 12'hFFF, 2);
      send_request(OP_INIT, 0, 0);
      send_request(OP_STEP, 16'h4000, 16'h4000);

      // random phases on small populations
      for (int phase = 0; phase < 6; phase++) begin
         configure($urandom, $urandom, $urandom, $urandom_range(10, 64), $urandom_range(1, 8));
         send_request(OP_INIT, $urandom, $urandom);
         random_steps(19);
      end
      // sender holds off until every result is back, then continues
      wait_idle();
      random_steps(6);

      wait_idle();
      repeat (200) @(negedge clock);
      $display("covered %0d init and %0d event requests over several configurations",
               init_count, step_count);
      $display("%0d results checked, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("household_sis_gillespie_step verification clean");
      else
         $display("household_sis_gillespie_step verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("household_sis_gillespie_step verification failed");
      $finish;
   end
endmodule

// ----- household_sis_gillespie_step.f -----
rtl/core/hss_pkg.sv
rtl/core/hss_div.sv
rtl/core/household_sis_gillespie_step.sv
verif/testbench.sv
